@@ rtl/idm_pkg.sv @@
// idm_pkg: shared types for the integer divide/modulo pipeline.
// No dependencies; used by every module of the divider.
`timescale 1ns / 1ps

package idm_pkg;

   // Sign and status flags that ride along with an operand pair
   typedef struct packed {
      logic neg_quot;   // quotient must be negated at the end
      logic neg_rem;    // remainder must be negated at the end
      logic div_zero;   // divisor was zero
   } side_type;

endpackage

@@ rtl/idm_prep.sv @@
// idm_prep: input stage; takes magnitudes of the operands and the sign flags.
// Depends on idm_pkg (side_type).
`timescale 1ns / 1ps

module idm_prep #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic                in_mode,
   input  logic [W-1:0]        in_dividend,
   input  logic [W-1:0]        in_divisor,
   output logic                out_valid,
   output logic [W-1:0]        out_mag_a,
   output logic [W-1:0]        out_mag_b,
   output idm_pkg::side_type   out_side
);

   logic              valid_ff;
   logic [W-1:0]      mag_a_ff, mag_a_in;
   logic [W-1:0]      mag_b_ff, mag_b_in;
   idm_pkg::side_type side_ff, side_in;
   logic              neg_a, neg_b;

   // sign detection and magnitude
   always_comb begin
      neg_a            = in_mode & in_dividend[W-1];
      neg_b            = in_mode & in_divisor[W-1];
      mag_a_in         = neg_a ? (~in_dividend + {{(W-1){1'b0}}, 1'b1}) : in_dividend;
      mag_b_in         = neg_b ? (~in_divisor + {{(W-1){1'b0}}, 1'b1}) : in_divisor;
      side_in.neg_quot = neg_a ^ neg_b;
      side_in.neg_rem  = neg_a;
      side_in.div_zero = (in_divisor == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (advance) begin
         mag_a_ff <= mag_a_in;
         mag_b_ff <= mag_b_in;
         side_ff  <= side_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_mag_a = mag_a_ff;
   assign out_mag_b = mag_b_ff;
   assign out_side  = side_ff;

endmodule

@@ rtl/idm_cell.sv @@
// idm_cell: one restoring-division step with its pipeline register.
// Depends on idm_pkg (side_type).
`timescale 1ns / 1ps

module idm_cell #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [W-1:0]        in_rem,
   input  logic [W-1:0]        in_dq,
   input  logic [W-1:0]        in_div,
   input  idm_pkg::side_type   in_side,
   output logic                out_valid,
   output logic [W-1:0]        out_rem,
   output logic [W-1:0]        out_dq,
   output logic [W-1:0]        out_div,
   output idm_pkg::side_type   out_side
);

   logic              valid_ff;
   logic [W-1:0]      rem_ff, rem_in;
   logic [W-1:0]      dq_ff, dq_in;
   logic [W-1:0]      div_ff;
   idm_pkg::side_type side_ff;
   logic [W:0]        shifted;
   logic [W:0]        diff;
   logic              fits;

   // shift in the next dividend bit, trial subtract, keep or restore
   always_comb begin
      shifted = {in_rem, in_dq[W-1]};
      diff    = shifted - {1'b0, in_div};
      fits    = (shifted >= {1'b0, in_div});
      rem_in  = fits ? diff[W-1:0] : shifted[W-1:0];
      dq_in   = {in_dq[W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff  <= rem_in;
         dq_ff   <= dq_in;
         div_ff  <= in_div;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_dq    = dq_ff;
   assign out_div   = div_ff;
   assign out_side  = side_ff;

endmodule

@@ rtl/idm_fix.sv @@
// idm_fix: output stage; restores signs and holds the result beat.
// Depends on idm_pkg (side_type).
`timescale 1ns / 1ps

module idm_fix #(
   parameter int W = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [W-1:0]        in_rem,
   input  logic [W-1:0]        in_quot,
   input  idm_pkg::side_type   in_side,
   output logic                out_valid,
   output logic [W-1:0]        out_quotient,
   output logic [W-1:0]        out_remainder,
   output logic                out_div_zero
);

   logic          valid_ff;
   logic [W-1:0]  quot_ff, quot_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic          dz_ff;

   // sign restore; for a zero divisor the quotient is forced to all ones and the remainder comes out as the dividend
   always_comb begin
      quot_in = in_side.neg_quot ? (~in_quot + {{(W-1){1'b0}}, 1'b1}) : in_quot;
      rem_in  = in_side.neg_rem ? (~in_rem + {{(W-1){1'b0}}, 1'b1}) : in_rem;
      if (in_side.div_zero) begin
         quot_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         dz_ff   <= in_side.div_zero;
      end
   end

   assign out_valid     = valid_ff;
   assign out_quotient  = quot_ff;
   assign out_remainder = rem_ff;
   assign out_div_zero  = dz_ff;

endmodule

@@ rtl/integer_divmod_unit.sv @@
// integer_divmod_unit: pipelined signed/unsigned divider with remainder.
// Depends on idm_pkg, idm_prep, idm_cell and idm_fix.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------------------
//   req     | in        | req_valid/req_stall| req_mode, req_dividend, req_divisor
//   rsp     | out       | rsp_valid/rsp_stall| rsp_quotient, rsp_remainder,
//           |           |                    | rsp_divide_by_zero
//
// One beat accepted per cycle while req_stall is low; a beat passes through the input
// stage, one cell per quotient bit and the output stage.
// Reset clears all stage valid bits; payload registers are not reset.
// While a result beat is held by rsp_stall the whole pipeline freezes and
// req_stall is raised; otherwise the pipeline moves every cycle.
`timescale 1ns / 1ps

module integer_divmod_unit #(
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_mode,
   input  logic [DATA_WIDTH-1:0] req_dividend,
   input  logic [DATA_WIDTH-1:0] req_divisor,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [DATA_WIDTH-1:0] rsp_quotient,
   output logic [DATA_WIDTH-1:0] rsp_remainder,
   output logic                  rsp_divide_by_zero
);

   localparam int W = DATA_WIDTH;

   logic              advance;
   logic              valid_s [0:W];
   logic [W-1:0]      rem_s   [0:W];
   logic [W-1:0]      dq_s    [0:W];
   logic [W-1:0]      div_s   [0:W];
   idm_pkg::side_type side_s  [0:W];

   // pipeline moves unless a result beat is held
   assign advance   = ~(rsp_valid & rsp_stall);
   assign req_stall = ~advance;

   idm_prep #(.W(W)) u_prep (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .in_valid    (req_valid),
      .in_mode     (req_mode),
      .in_dividend (req_dividend),
      .in_divisor  (req_divisor),
      .out_valid   (valid_s[0]),
      .out_mag_a   (dq_s[0]),
      .out_mag_b   (div_s[0]),
      .out_side    (side_s[0])
   );

   // partial remainder starts at zero
   assign rem_s[0] = '0;

   // one cell per quotient bit
   for (genvar i = 0; i < W; i++) begin : g_cell
      idm_cell #(.W(W)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (valid_s[i]),
         .in_rem    (rem_s[i]),
         .in_dq     (dq_s[i]),
         .in_div    (div_s[i]),
         .in_side   (side_s[i]),
         .out_valid (valid_s[i+1]),
         .out_rem   (rem_s[i+1]),
         .out_dq    (dq_s[i+1]),
         .out_div   (div_s[i+1]),
         .out_side  (side_s[i+1])
      );
   end

   idm_fix #(.W(W)) u_fix (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .in_valid      (valid_s[W]),
      .in_rem        (rem_s[W]),
      .in_quot       (dq_s[W]),
      .in_side       (side_s[W]),
      .out_valid     (rsp_valid),
      .out_quotient  (rsp_quotient),
      .out_remainder (rsp_remainder),
      .out_div_zero  (rsp_divide_by_zero)
   );

   // a zero divisor always reports an all-ones quotient
   a_dz_quot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_divide_by_zero) |-> (rsp_quotient == {W{1'b1}}))
      else $error("divide by zero without all-ones quotient");

   // an accepted request shows up in the input stage
   a_req_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> valid_s[0])
      else $error("accepted request lost at input stage");

   // a held result freezes the last cell so nothing is overwritten
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(valid_s[W]) && $stable(dq_s[W])))
      else $error("pipeline moved while result was held");

endmodule

@@ tb/sv/integer_divmod_unit_tb.sv @@
// integer_divmod_unit_tb: self-checking bench for the pipelined divide/modulo unit.
// Drives directed and random operand pairs with random idles and stalls; needs only the RTL.
`timescale 1ns / 1ps

module integer_divmod_unit_tb;

   localparam int W            = 32;
   localparam int IDLE_LIMIT   = 2000;  // cycles with no beat on either side
   localparam int DRAIN_CYCLES = 40;    // pipeline depth is W + 2
   localparam int RANDOM_OPS   = 1150;
   localparam int MAX_REPORTS  = 50;

   localparam bit MODE_UNSIGNED = 1'b0;
   localparam bit MODE_SIGNED   = 1'b1;

   localparam logic [W-1:0] ALL_ONES = '1;
   localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

   // One operand pair; known marks a row whose result is typed in by hand
   typedef struct packed {
      logic         mode;
      logic [W-1:0] dividend;
      logic [W-1:0] divisor;
      logic         known;
      logic [W-1:0] quot;
      logic [W-1:0] rem;
      logic         dz;
   } div_row_type;

   typedef struct packed {
      logic [W-1:0] quot;
      logic [W-1:0] rem;
      logic         dz;
   } div_result_type;

   localparam int N_DIRECTED = 21;

   // Directed rows: extremes, zero divisor in both modes, most negative over minus one
   div_row_type directed_rows [0:N_DIRECTED-1] = '{
      '{MODE_UNSIGNED, 32'h0000_0000, 32'h0000_0001, 1'b1, 32'h0000_0000, 32'h0000_0000, 1'b0},
      '{MODE_UNSIGNED, ALL_ONES,      32'h0000_0001, 1'b1, ALL_ONES,      32'h0000_0000, 1'b0},
      '{MODE_UNSIGNED, ALL_ONES,      ALL_ONES,      1'b1, 32'h0000_0001, 32'h0000_0000, 1'b0},
      '{MODE_UNSIGNED, 32'h1234_5678, 32'h0000_0000, 1'b1, ALL_ONES,      32'h1234_5678, 1'b1},
      '{MODE_SIGNED,   MOST_NEG,      32'h0000_0000, 1'b1, ALL_ONES,      MOST_NEG,      1'b1},
      '{MODE_UNSIGNED, 32'h0000_0000, 32'h0000_0000, 1'b1, ALL_ONES,      32'h0000_0000, 1'b1},
      '{MODE_SIGNED,   ALL_ONES,      32'h0000_0000, 1'b1, ALL_ONES,      ALL_ONES,      1'b1},
      '{MODE_SIGNED,   MOST_NEG,      ALL_ONES,      1'b1, MOST_NEG,      32'h0000_0000, 1'b0},
      '{MODE_SIGNED,   MOST_NEG,      32'h0000_0001, 1'b1, MOST_NEG,      32'h0000_0000, 1'b0},
      '{MODE_SIGNED,   MOST_POS,      ALL_ONES,      1'b1, 32'h8000_0001, 32'h0000_0000, 1'b0},
      '{MODE_UNSIGNED, MOST_NEG,      ALL_ONES,      1'b1, 32'h0000_0000, MOST_NEG,      1'b0},
      '{MODE_SIGNED,   MOST_POS,      MOST_NEG,      1'b1, 32'h0000_0000, MOST_POS,      1'b0},
      '{MODE_UNSIGNED, ALL_ONES,      MOST_NEG,      1'b1, 32'h0000_0001, MOST_POS,      1'b0},
      '{MODE_SIGNED,   32'h0000_0001, ALL_ONES,      1'b1, ALL_ONES,      32'h0000_0000, 1'b0},
      '{MODE_SIGNED,   32'hFFFF_FFF9, 32'h0000_0002, 1'b0, '0, '0, 1'b0},
      '{MODE_SIGNED,   32'h0000_0007, 32'hFFFF_FFFE, 1'b0, '0, '0, 1'b0},
      '{MODE_SIGNED,   32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b0, '0, '0, 1'b0},
      '{MODE_SIGNED,   32'h0000_0007, 32'h0000_0002, 1'b0, '0, '0, 1'b0},
      '{MODE_UNSIGNED, 32'h0000_0064, 32'h0000_0007, 1'b0, '0, '0, 1'b0},
      '{MODE_SIGNED,   MOST_NEG,      MOST_POS,      1'b0, '0, '0, 1'b0},
      '{MODE_UNSIGNED, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, '0, '0, 1'b0}
   };

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   logic         req_mode;
   logic [W-1:0] req_dividend;
   logic [W-1:0] req_divisor;
   logic         rsp_valid;
   logic         rsp_stall;
   logic [W-1:0] rsp_quotient;
   logic [W-1:0] rsp_remainder;
   logic         rsp_divide_by_zero;

   div_row_type    pending_ops [$];   // operand pairs not yet driven
   div_result_type expected_divs [$]; // results owed by the divider, oldest first
   div_row_type    beat_on_bus;
   div_row_type    next_op;
   div_result_type oldest;
   logic           req_taken;
   logic           quiet;
   int             ops_sent;
   int             errors;
   int             idle_cycles;

   integer_divmod_unit #(.DATA_WIDTH(W)) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_mode           (req_mode),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   always #2 clock = ~clock;

   // No idles or stalls while this window of beats goes through
   assign quiet = (ops_sent >= 300) && (ops_sent < 650);

   // Quotient and remainder as the divider must produce them
   function automatic div_result_type divmod_predict(logic mode, logic [W-1:0] a,
                                                     logic [W-1:0] b);
      div_result_type res;
      logic           neg_a;
      logic           neg_b;
      logic [W-1:0]   mag_a;
      logic [W-1:0]   mag_b;
      res.dz = 1'b0;
      if (b == '0) begin
         res.quot = ALL_ONES;
         res.rem  = a;
         res.dz   = 1'b1;
      end else if (mode == MODE_UNSIGNED) begin
         res.quot = a / b;
         res.rem  = a % b;
      end else begin
         neg_a = a[W-1];
         neg_b = b[W-1];
         mag_a = neg_a ? -a : a;
         mag_b = neg_b ? -b : b;
         res.quot = mag_a / mag_b;
         res.rem  = mag_a % mag_b;
         if (neg_a != neg_b) res.quot = -res.quot;
         if (neg_a) res.rem = -res.rem;
      end
      return res;
   endfunction

   // Operand with a bias toward edges, small and negative values
   function automatic logic [W-1:0] pick_operand();
      logic [W-1:0] v;
      case ($urandom_range(9))
         5: v = $urandom_range(15);
         6: begin
            case ($urandom_range(4))
               0: v = '0;
               1: v = 1;
               2: v = ALL_ONES;
               3: v = MOST_NEG;
               default: v = MOST_POS;
            endcase
         end
         7: v = -$urandom_range(15, 1);
         8: v = $urandom >> $urandom_range(W-1);
         9: v = 1 << $urandom_range(W-1);
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
      errors++;
      if (errors <= MAX_REPORTS)
         $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
   endtask

   // Sender: new beat at the falling edge once the last one was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (pending_ops.size() == 0 || (!quiet && $urandom_range(99) < 10)) begin
            req_valid <= 1'b0;
         end else begin
            next_op = pending_ops.pop_front();
            req_valid    <= 1'b1;
            req_mode     <= next_op.mode;
            req_dividend <= next_op.dividend;
            req_divisor  <= next_op.divisor;
            beat_on_bus  <= next_op;
         end
      end
   end

   // Receiver: random stalls outside the quiet window
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 10);
   end

   // Record accepted operands and check result beats at the rising edge
   always @(posedge clock) begin
      req_taken <= req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_divs.size() == 0) begin
            report_mismatch("result beat with nothing expected", rsp_quotient, '0);
         end else begin
            oldest = expected_divs.pop_front();
            if (rsp_quotient !== oldest.quot)
               report_mismatch("quotient", rsp_quotient, oldest.quot);
            if (rsp_remainder !== oldest.rem)
               report_mismatch("remainder", rsp_remainder, oldest.rem);
            if (rsp_divide_by_zero !== oldest.dz)
               report_mismatch("divide_by_zero", W'(rsp_divide_by_zero), W'(oldest.dz));
         end
      end
      if (!reset && req_valid && !req_stall) begin
         ops_sent <= ops_sent + 1;
         if (beat_on_bus.known)
            expected_divs.push_back({beat_on_bus.quot, beat_on_bus.rem, beat_on_bus.dz});
         else
            expected_divs.push_back(divmod_predict(beat_on_bus.mode, beat_on_bus.dividend,
                                                   beat_on_bus.divisor));
      end
   end

   // Watchdog on cycles without any beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      div_row_type op;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_mode     = MODE_UNSIGNED;
      req_dividend = '0;
      req_divisor  = '0;
      rsp_stall    = 1'b0;
      req_taken    = 1'b0;
      beat_on_bus  = '0;
      ops_sent     = 0;
      errors       = 0;
      idle_cycles  = 0;

      // Directed table first, then random pairs
      for (int i = 0; i < N_DIRECTED; i++)
         pending_ops.push_back(directed_rows[i]);
      for (int i = 0; i < RANDOM_OPS; i++) begin
         op          = '0;
         op.mode     = $urandom_range(1);
         op.dividend = pick_operand();
         op.divisor  = ($urandom_range(99) < 5) ? '0 : pick_operand();
         pending_ops.push_back(op);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: all beats sent and all results back, then let the pipe settle;
      // checked at the rising edge, where the sender's queue and valid are steady
      do @(posedge clock);
      while (pending_ops.size() != 0 || req_valid || expected_divs.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (expected_divs.size() != 0)
         report_mismatch("results never delivered", W'(expected_divs.size()), '0);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
